### design/bnms_pkg.sv
// Package for the box non-maximum suppression core.
// Field widths, action and register codes, candidate word layout, sequencer states.
// No dependencies.
package bnms_pkg;

    localparam int COORD_W = 14;   // Q10.4 input coordinates
    localparam int PROB_W  = 16;   // Q0.16 probabilities
    localparam int EDGE_W  = 17;   // stored corners, signed
    localparam int OUT_W   = 16;   // output corners
    localparam int CLS_W   = 7;
    localparam int AREA_W  = 2 * COORD_W;
    localparam int UNI_W   = AREA_W + 2;
    localparam int MUL_A_W = UNI_W;
    localparam int MUL_B_W = PROB_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int REG_IDX_W = 1;

    typedef enum logic [1:0] {
        ACT_HEADER = 2'd0,
        ACT_CLASS  = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCORE_THR = 1'b0,
        REG_IOU_THR   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic signed [EDGE_W-1:0] l;
        logic signed [EDGE_W-1:0] t;
        logic signed [EDGE_W-1:0] r;
        logic signed [EDGE_W-1:0] b;
        logic [PROB_W-1:0]        score;
        logic [CLS_W-1:0]         cls;
    } cand_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CL_MUL,
        S_CL_WR,
        S_SC_START,
        S_SC_RD,
        S_SC_CHK,
        S_SC_DONE,
        S_EMIT,
        S_BEST_RD,
        S_BEST_LD,
        S_SUP_RD,
        S_SUP_GEO,
        S_M_INTER,
        S_M_AREA_A,
        S_M_AREA_B,
        S_M_UNION,
        S_M_THR,
        S_SUP_CMP,
        S_FIN
    } state_t;

endpackage

### design/bnms_if.sv
// Handshake channels of the box non-maximum suppression core.
// Depends on bnms_pkg for field widths.
interface bnms_in_if;
    import bnms_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;
    logic [COORD_W-1:0]   box_width;
    logic [COORD_W-1:0]   box_height;
    logic [PROB_W-1:0]    objectness;
    logic [PROB_W-1:0]    cls_prob;
    modport source (output valid, action, pos_x, pos_y, box_width, box_height,
                    objectness, cls_prob, input ready);
    modport sink (input valid, action, pos_x, pos_y, box_width, box_height,
                  objectness, cls_prob, output ready);
endinterface

interface bnms_out_if;
    import bnms_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  left_edge;
    logic signed [OUT_W-1:0]  top_edge;
    logic signed [OUT_W-1:0]  right_edge;
    logic signed [OUT_W-1:0]  bottom_edge;
    logic [PROB_W-1:0]        final_score;
    logic [CLS_W-1:0]         class_index;
    logic                     nothing_kept;
    logic                     overflowed;
    logic                     last;
    modport source (output valid, left_edge, top_edge, right_edge, bottom_edge,
                    final_score, class_index, nothing_kept, overflowed, last, input ready);
    modport sink (input valid, left_edge, top_edge, right_edge, bottom_edge,
                  final_score, class_index, nothing_kept, overflowed, last, output ready);
endinterface

### design/bnms_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### design/box_non_max_suppression_core.sv
// Box non-maximum suppression core: candidate loading, score gate, greedy IoU pass.
// Depends on bnms_pkg, bnms_if (channels) and bnms_ram (candidate store).
//
//  channel  | dir | handshake      | carries
//  in_ch    | in  | valid/ready    | action, centre, size, objectness, class score
//  out_ch   | out | valid/ready    | kept box corners, score, class, flags, last
//  cfg      | in  | cfg_we         | score / IoU thresholds by index
//
// Class items are handled in the idle state itself; header items pass a score multiply and a store write.
// Finish: the pending box closes likewise, then per kept box a scan of the stored
// candidates for the best alive score, a winner fetch and a pass over them, each alive
// one through the shared 30x16 multiplier. in_ch is ready only when idle.
// out_ch holds its item until taken; the sequencer waits. No clearing pass.
module box_non_max_suppression_core #(
    parameter int MAX_CANDIDATES = 64,
    parameter int NUM_CLASSES    = 80
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bnms_in_if.sink                         in_ch,
    bnms_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [bnms_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [bnms_pkg::PROB_W-1:0]     cfg_data
);
    import bnms_pkg::*;

    localparam int CW    = $clog2(MAX_CANDIDATES + 1);
    localparam int IW    = $clog2(MAX_CANDIDATES);
    localparam int CNT_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int CAND_W = $bits(cand_t);

    state_t state_reg, state_next;

    logic [PROB_W-1:0] score_thr_reg, score_thr_next;
    logic [PROB_W-1:0] iou_thr_reg, iou_thr_next;

    // pending box
    logic               pend_reg, pend_next;
    logic               full_reg, full_next;
    logic [COORD_W-1:0] hcx_reg, hcx_next, hcy_reg, hcy_next;
    logic [COORD_W-1:0] hw_reg, hw_next, hh_reg, hh_next;
    logic [PROB_W-1:0]  hobj_reg, hobj_next;
    logic [PROB_W-1:0]  best_s_reg, best_s_next;
    logic [CNT_W-1:0]   ccnt_reg, ccnt_next;
    logic [CLS_W-1:0]   best_c_reg, best_c_next;

    // incoming item held while the old box closes
    logic [1:0]         act_reg, act_next;
    logic [COORD_W-1:0] icx_reg, icx_next, icy_reg, icy_next;
    logic [COORD_W-1:0] iw_in_reg, iw_in_next, ih_in_reg, ih_in_next;
    logic [PROB_W-1:0]  iobj_reg, iobj_next;

    logic [CW-1:0]             count_reg, count_next;
    logic [MAX_CANDIDATES-1:0] alive_reg, alive_next;
    logic                      ovf_reg, ovf_next;

    logic [CW-1:0]      idx_reg, idx_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      bidx_reg, bidx_next;
    logic [PROB_W-1:0]  bscore_reg, bscore_next;
    logic               more_reg, more_next;

    cand_t              bbox_reg, bbox_next;
    logic [COORD_W-1:0] bw_reg, bw_next, bh_reg, bh_next;
    logic [COORD_W-1:0] cw_reg, cw_next, ch_reg, ch_next;
    logic [COORD_W-1:0] xw_reg, xw_next, xh_reg, xh_next;
    logic [AREA_W-1:0]  inter_reg, inter_next, area_a_reg, area_a_next;
    logic [UNI_W-1:0]   uni_reg, uni_next;

    // shared multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_reg;

    // output register
    logic               opend_reg, opend_next;
    cand_t              obox_reg, obox_next;
    logic               onk_reg, onk_next, oovf_reg, oovf_next, olast_reg, olast_next;

    // candidate store
    logic               ram_we;
    logic [IW-1:0]      ram_raddr;
    cand_t              ram_wdata, ram_rdata;
    logic [CAND_W-1:0]  ram_rdata_raw;

    bnms_ram #(.WIDTH(CAND_W), .DEPTH(MAX_CANDIDATES)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );
    assign ram_rdata = cand_t'(ram_rdata_raw);

    // corner conversion of the pending box
    logic signed [EDGE_W-1:0] new_l, new_t;
    logic [PROB_W-1:0]        new_score;
    always_comb
    begin
        new_l     = $signed({3'b000, hcx_reg}) - $signed({4'b0000, hw_reg[COORD_W-1:1]});
        new_t     = $signed({3'b000, hcy_reg}) - $signed({4'b0000, hh_reg[COORD_W-1:1]});
        new_score = prod_reg[2*PROB_W-1:PROB_W];
        ram_wdata.l     = new_l;
        ram_wdata.t     = new_t;
        ram_wdata.r     = new_l + $signed({3'b000, hw_reg});
        ram_wdata.b     = new_t + $signed({3'b000, hh_reg});
        ram_wdata.score = new_score;
        ram_wdata.cls   = best_c_reg;
    end

    // overlap geometry of the candidate just read against the current winner
    logic signed [EDGE_W-1:0] ov_l, ov_t, ov_r, ov_b;
    logic signed [EDGE_W:0]   dx, dy, dcw, dch;
    always_comb
    begin
        ov_l = (bbox_reg.l > ram_rdata.l) ? bbox_reg.l : ram_rdata.l;
        ov_t = (bbox_reg.t > ram_rdata.t) ? bbox_reg.t : ram_rdata.t;
        ov_r = (bbox_reg.r < ram_rdata.r) ? bbox_reg.r : ram_rdata.r;
        ov_b = (bbox_reg.b < ram_rdata.b) ? bbox_reg.b : ram_rdata.b;
        dx   = {ov_r[EDGE_W-1], ov_r} - {ov_l[EDGE_W-1], ov_l};
        dy   = {ov_b[EDGE_W-1], ov_b} - {ov_t[EDGE_W-1], ov_t};
        dcw  = {ram_rdata.r[EDGE_W-1], ram_rdata.r} - {ram_rdata.l[EDGE_W-1], ram_rdata.l};
        dch  = {ram_rdata.b[EDGE_W-1], ram_rdata.b} - {ram_rdata.t[EDGE_W-1], ram_rdata.t};
    end

    logic [IW-1:0] idx_lo;
    logic          last_idx;
    assign idx_lo   = idx_reg[IW-1:0];
    assign last_idx = (idx_reg + CW'(1)) == count_reg;

    always_comb
    begin
        state_next    = state_reg;
        score_thr_next = score_thr_reg;
        iou_thr_next  = iou_thr_reg;
        pend_next     = pend_reg;
        full_next     = full_reg;
        hcx_next      = hcx_reg;
        hcy_next      = hcy_reg;
        hw_next       = hw_reg;
        hh_next       = hh_reg;
        hobj_next     = hobj_reg;
        best_s_next   = best_s_reg;
        ccnt_next     = ccnt_reg;
        best_c_next   = best_c_reg;
        act_next      = act_reg;
        icx_next      = icx_reg;
        icy_next      = icy_reg;
        iw_in_next    = iw_in_reg;
        ih_in_next    = ih_in_reg;
        iobj_next     = iobj_reg;
        count_next    = count_reg;
        alive_next    = alive_reg;
        ovf_next      = ovf_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        bidx_next     = bidx_reg;
        bscore_next   = bscore_reg;
        more_next     = more_reg;
        bbox_next     = bbox_reg;
        bw_next       = bw_reg;
        bh_next       = bh_reg;
        cw_next       = cw_reg;
        ch_next       = ch_reg;
        xw_next       = xw_reg;
        xh_next       = xh_reg;
        inter_next    = inter_reg;
        area_a_next   = area_a_reg;
        uni_next      = uni_reg;
        opend_next    = opend_reg;
        obox_next     = obox_reg;
        onk_next      = onk_reg;
        oovf_next     = oovf_reg;
        olast_next    = olast_reg;
        mul_a         = MUL_A_W'(hobj_reg);
        mul_b         = best_s_reg;
        ram_we        = 1'b0;
        ram_raddr     = idx_lo;
        in_ch.ready   = 1'b0;
        out_ch.valid  = 1'b0;

        if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SCORE_THR: score_thr_next = cfg_data;
                REG_IOU_THR:   iou_thr_next   = cfg_data;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    act_next   = in_ch.action;
                    icx_next   = in_ch.pos_x;
                    icy_next   = in_ch.pos_y;
                    iw_in_next = in_ch.box_width;
                    ih_in_next = in_ch.box_height;
                    iobj_next  = in_ch.objectness;
                    unique case (action_t'(in_ch.action))
                        ACT_HEADER, ACT_FINISH: state_next = S_CL_MUL;
                        ACT_CLASS:
                        begin
                            if (pend_reg && !full_reg)
                            begin
                                if (in_ch.cls_prob > best_s_reg)
                                begin
                                    best_s_next = in_ch.cls_prob;
                                    best_c_next = CLS_W'(ccnt_reg);
                                end
                                if (ccnt_reg == CNT_W'(NUM_CLASSES - 1))
                                begin
                                    full_next = 1'b1;
                                end
                                else
                                begin
                                    ccnt_next = ccnt_reg + CNT_W'(1);
                                end
                            end
                        end
                        ACT_NONE: ;
                    endcase
                end
            end

            S_CL_MUL:
            begin
                state_next = S_CL_WR;
            end

            S_CL_WR:
            begin
                if (pend_reg && (new_score > score_thr_reg))
                begin
                    if (count_reg == CW'(MAX_CANDIDATES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        alive_next[count_reg[IW-1:0]] = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                pend_next = 1'b0;
                if (action_t'(act_reg) == ACT_HEADER)
                begin
                    hcx_next    = icx_reg;
                    hcy_next    = icy_reg;
                    hw_next     = iw_in_reg;
                    hh_next     = ih_in_reg;
                    hobj_next   = iobj_reg;
                    pend_next   = 1'b1;
                    full_next   = 1'b0;
                    best_s_next = '0;
                    best_c_next = '0;
                    ccnt_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_SC_START;
                end
            end

            S_SC_START:
            begin
                idx_next   = '0;
                found_next = 1'b0;
                state_next = (count_reg == '0) ? S_SC_DONE : S_SC_RD;
            end

            S_SC_RD:
            begin
                state_next = S_SC_CHK;
            end

            S_SC_CHK:
            begin
                if (alive_reg[idx_lo] && (!found_reg || (ram_rdata.score > bscore_reg)))
                begin
                    found_next  = 1'b1;
                    bidx_next   = idx_lo;
                    bscore_next = ram_rdata.score;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = last_idx ? S_SC_DONE : S_SC_RD;
            end

            S_SC_DONE:
            begin
                more_next = found_reg;
                if (found_reg)
                begin
                    olast_next = 1'b0;
                    state_next = opend_reg ? S_EMIT : S_BEST_RD;
                end
                else
                begin
                    olast_next = 1'b1;
                    if (!opend_reg)
                    begin
                        obox_next  = '0;
                        onk_next   = 1'b1;
                        oovf_next  = ovf_reg;
                        opend_next = 1'b1;
                    end
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                out_ch.valid = 1'b1;
                if (out_ch.ready)
                begin
                    opend_next = 1'b0;
                    state_next = more_reg ? S_BEST_RD : S_FIN;
                end
            end

            S_BEST_RD:
            begin
                ram_raddr  = bidx_reg;
                state_next = S_BEST_LD;
            end

            S_BEST_LD:
            begin
                bbox_next  = ram_rdata;
                bw_next    = dcw[COORD_W-1:0];
                bh_next    = dch[COORD_W-1:0];
                alive_next[bidx_reg] = 1'b0;
                obox_next  = ram_rdata;
                onk_next   = 1'b0;
                oovf_next  = ovf_reg;
                opend_next = 1'b1;
                idx_next   = '0;
                state_next = S_SUP_RD;
            end

            S_SUP_RD:
            begin
                state_next = S_SUP_GEO;
            end

            S_SUP_GEO:
            begin
                xw_next = (ov_r > ov_l) ? dx[COORD_W-1:0] : '0;
                xh_next = (ov_b > ov_t) ? dy[COORD_W-1:0] : '0;
                cw_next = dcw[COORD_W-1:0];
                ch_next = dch[COORD_W-1:0];
                if (alive_reg[idx_lo])
                begin
                    state_next = S_M_INTER;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = last_idx ? S_SC_START : S_SUP_RD;
                end
            end

            S_M_INTER:
            begin
                mul_a      = MUL_A_W'(xw_reg);
                mul_b      = MUL_B_W'(xh_reg);
                state_next = S_M_AREA_A;
            end

            S_M_AREA_A:
            begin
                inter_next = prod_reg[AREA_W-1:0];
                mul_a      = MUL_A_W'(bw_reg);
                mul_b      = MUL_B_W'(bh_reg);
                state_next = S_M_AREA_B;
            end

            S_M_AREA_B:
            begin
                area_a_next = prod_reg[AREA_W-1:0];
                mul_a       = MUL_A_W'(cw_reg);
                mul_b       = MUL_B_W'(ch_reg);
                state_next  = S_M_UNION;
            end

            S_M_UNION:
            begin
                uni_next   = UNI_W'(area_a_reg) + UNI_W'(prod_reg[AREA_W-1:0])
                           - UNI_W'(inter_reg);
                state_next = S_M_THR;
            end

            S_M_THR:
            begin
                mul_a      = uni_reg;
                mul_b      = iou_thr_reg;
                state_next = S_SUP_CMP;
            end

            S_SUP_CMP:
            begin
                // zero union counts as overlapping
                if ((uni_reg == '0) || (PROD_W'({inter_reg, 16'h0000}) > prod_reg))
                begin
                    alive_next[idx_lo] = 1'b0;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = last_idx ? S_SC_START : S_SUP_RD;
            end

            S_FIN:
            begin
                alive_next  = '0;
                count_next  = '0;
                ovf_next    = 1'b0;
                pend_next   = 1'b0;
                full_next   = 1'b0;
                hcx_next    = '0;
                hcy_next    = '0;
                hw_next     = '0;
                hh_next     = '0;
                hobj_next   = '0;
                best_s_next = '0;
                best_c_next = '0;
                ccnt_next   = '0;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_ch.left_edge    = obox_reg.l[OUT_W-1:0];
    assign out_ch.top_edge     = obox_reg.t[OUT_W-1:0];
    assign out_ch.right_edge   = obox_reg.r[OUT_W-1:0];
    assign out_ch.bottom_edge  = obox_reg.b[OUT_W-1:0];
    assign out_ch.final_score  = obox_reg.score;
    assign out_ch.class_index  = obox_reg.cls;
    assign out_ch.nothing_kept = onk_reg;
    assign out_ch.overflowed   = oovf_reg;
    assign out_ch.last         = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            score_thr_reg <= PROB_W'(32768);
            iou_thr_reg   <= PROB_W'(19661);
            pend_reg      <= 1'b0;
            full_reg      <= 1'b0;
            hcx_reg       <= '0;
            hcy_reg       <= '0;
            hw_reg        <= '0;
            hh_reg        <= '0;
            hobj_reg      <= '0;
            best_s_reg    <= '0;
            ccnt_reg      <= '0;
            best_c_reg    <= '0;
            count_reg     <= '0;
            alive_reg     <= '0;
            ovf_reg       <= 1'b0;
            opend_reg     <= 1'b0;
            more_reg      <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            score_thr_reg <= score_thr_next;
            iou_thr_reg   <= iou_thr_next;
            pend_reg      <= pend_next;
            full_reg      <= full_next;
            hcx_reg       <= hcx_next;
            hcy_reg       <= hcy_next;
            hw_reg        <= hw_next;
            hh_reg        <= hh_next;
            hobj_reg      <= hobj_next;
            best_s_reg    <= best_s_next;
            ccnt_reg      <= ccnt_next;
            best_c_reg    <= best_c_next;
            count_reg     <= count_next;
            alive_reg     <= alive_next;
            ovf_reg       <= ovf_next;
            opend_reg     <= opend_next;
            more_reg      <= more_next;
            found_reg     <= found_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        icx_reg    <= icx_next;
        icy_reg    <= icy_next;
        iw_in_reg  <= iw_in_next;
        ih_in_reg  <= ih_in_next;
        iobj_reg   <= iobj_next;
        bidx_reg   <= bidx_next;
        bscore_reg <= bscore_next;
        bbox_reg   <= bbox_next;
        bw_reg     <= bw_next;
        bh_reg     <= bh_next;
        cw_reg     <= cw_next;
        ch_reg     <= ch_next;
        xw_reg     <= xw_next;
        xh_reg     <= xh_next;
        inter_reg  <= inter_next;
        area_a_reg <= area_a_next;
        uni_reg    <= uni_next;
        obox_reg   <= obox_next;
        onk_reg    <= onk_next;
        oovf_reg   <= oovf_next;
        olast_reg  <= olast_next;
        prod_reg   <= mul_a * mul_b;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_CANDIDATES))
        else $error("candidate count beyond capacity");

    a_alive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (alive_reg >> count_reg) == '0)
        else $error("live candidate above fill count");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while a result is offered");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.nothing_kept |-> out_ch.last)
        else $error("empty result not marked last");

    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> count_reg == '0 && alive_reg == '0 && !ovf_reg)
        else $error("set not cleared after run");
`endif
endmodule
